### rtl/cbpg_pkg.sv
package cbpg_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int CNT_W           = 7;

endpackage

### rtl/cbpg_front.sv
// front end: takes a command, clamps the count and parks it in a small queue
module cbpg_front #(
    parameter int COORD_BITS = cbpg_pkg::COORD_BITS_DEF,
    parameter int MAX_POINTS = cbpg_pkg::MAX_POINTS_DEF,
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic signed [COORD_BITS-1:0] cx_in [4],
    input  logic signed [COORD_BITS-1:0] cy_in [4],
    input  logic [cbpg_pkg::CNT_W-1:0]   cnt_in,
    output logic                         full,
    output logic                         avail,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] cx_out [4],
    output logic signed [COORD_BITS-1:0] cy_out [4],
    output logic [CW-1:0]                cnt_out
);
    // two entry queue
    logic signed [COORD_BITS-1:0] qx_reg [2][4];
    logic signed [COORD_BITS-1:0] qy_reg [2][4];
    logic [CW-1:0] qn_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] fill_reg;
    logic [CW-1:0] clamped;

    always_comb
    begin
        if (cnt_in > cbpg_pkg::CNT_W'(MAX_POINTS))
            clamped = CW'(MAX_POINTS);
        else
            clamped = CW'(cnt_in);
    end

    assign full  = (fill_reg == 2'd2);
    assign avail = (fill_reg != 2'd0);
    assign cx_out  = qx_reg[rp_reg];
    assign cy_out  = qy_reg[rp_reg];
    assign cnt_out = qn_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && clamped != '0)
        begin
            qx_reg[wp_reg] <= cx_in;
            qy_reg[wp_reg] <= cy_in;
            qn_reg[wp_reg] <= clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            // zero counts are dropped here
            if (push && clamped != '0)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            fill_reg <= fill_reg + 2'(push && clamped != '0) - 2'(pop);
        end
    end
endmodule

### rtl/cbpg_back.sv
// back end: one point per pass through a sequenced datapath
module cbpg_back #(
    parameter int COORD_BITS  = cbpg_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbpg_pkg::T_FRAC_BITS_DEF,
    parameter int MAX_POINTS  = cbpg_pkg::MAX_POINTS_DEF,
    parameter int CW          = $clog2(MAX_POINTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         avail,
    output logic                         pop,
    output logic                         idle,
    input  logic signed [COORD_BITS-1:0] cx [4],
    input  logic signed [COORD_BITS-1:0] cy [4],
    input  logic [CW-1:0]                cnt,
    output logic                         strobe,
    output logic signed [COORD_BITS-1:0] pt_x,
    output logic signed [COORD_BITS-1:0] pt_y,
    output logic [5:0]                   pt_index,
    output logic                         last
);
    localparam int F  = T_FRAC_BITS;
    localparam int TW = F + 1;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = IW + F + 1;
    localparam int DW = $clog2(NW + 1);
    localparam int WW = F + 3;
    localparam int AW = WW + COORD_BITS + 3;
    localparam logic [TW-1:0] ONE  = TW'(1) << F;
    localparam logic [TW-1:0] HALF = TW'(1) << (F - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_S, S_U, S_SQ, S_W, S_AX, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [COORD_BITS-1:0] px_reg [4];
    logic signed [COORD_BITS-1:0] py_reg [4];
    logic [CW-1:0] n_reg;
    logic [IW-1:0] i_reg;
    logic [NW-1:0] rem_reg, quo_reg;
    logic [DW-1:0] dcnt_reg;
    logic [TW-1:0] t_reg, s_reg, u_reg, s2_reg, u2_reg;
    logic [WW-1:0] w_reg [4];
    logic [1:0]    k_reg;
    logic signed [AW-1:0] ax_reg, ay_reg;

    // rounding multiplier function, Q1.F times Q1.F
    function automatic logic [TW-1:0] qmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [2*TW-1:0] p;
        p = a * b + (2*TW)'(HALF);
        return p[F +: TW];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] fin(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] sh;
        sh = (acc + $signed(AW'(HALF))) >>> F;
        if (sh > AW'((1 << (COORD_BITS - 1)) - 1))
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (sh < -(AW'(1) << (COORD_BITS - 1)))
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            return sh[COORD_BITS-1:0];
    endfunction

    logic [NW-1:0] dvs, trial;
    logic [NW:0] rsh;
    assign dvs   = NW'(n_reg) - NW'(1);
    assign rsh   = {rem_reg, quo_reg[NW-1]};
    assign trial = rsh[NW-1:0] - dvs;

    assign pop  = (state_reg == S_IDLE) && avail;
    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            strobe    <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        px_reg <= cx;
                        py_reg <= cy;
                        n_reg  <= cnt;
                        i_reg  <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // dividend i*ONE + (n-1)/2, restoring division one bit a cycle
                    rem_reg  <= '0;
                    quo_reg  <= (NW'(i_reg) << F) + (dvs >> 1);
                    dcnt_reg <= '0;
                    if (n_reg == CW'(1))
                    begin
                        t_reg     <= '0;
                        state_reg <= S_S;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rsh[NW] || rsh[NW-1:0] >= dvs)
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh[NW-1:0];
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + DW'(1);
                    if (int'(dcnt_reg) == NW - 1)
                        state_reg <= S_S;
                end
                S_S:
                begin
                    if (n_reg != CW'(1))
                        t_reg <= quo_reg[TW-1:0];
                    state_reg <= S_U;
                end
                S_U:
                begin
                    if (t_reg < HALF)
                        s_reg <= qmul(t_reg, t_reg);
                    else
                        s_reg <= ONE - qmul(ONE - t_reg, ONE - t_reg);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    u_reg  <= ONE - s_reg;
                    s2_reg <= qmul(s_reg, s_reg);
                    u2_reg <= qmul(ONE - s_reg, ONE - s_reg);
                    k_reg  <= '0;
                    state_reg <= S_W;
                end
                S_W:
                begin
                    w_reg[0] <= WW'(qmul(u2_reg, u_reg));
                    w_reg[1] <= WW'(qmul(u2_reg, s_reg)) * WW'(3);
                    w_reg[2] <= WW'(qmul(s2_reg, u_reg)) * WW'(3);
                    w_reg[3] <= WW'(qmul(s2_reg, s_reg));
                    ax_reg <= '0;
                    ay_reg <= '0;
                    state_reg <= S_AX;
                end
                S_AX:
                begin
                    // one weight per cycle, both axes
                    ax_reg <= ax_reg + AW'($signed({1'b0, w_reg[k_reg]}) * px_reg[k_reg]);
                    ay_reg <= ay_reg + AW'($signed({1'b0, w_reg[k_reg]}) * py_reg[k_reg]);
                    k_reg  <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    strobe   <= 1'b1;
                    pt_x     <= fin(ax_reg);
                    pt_y     <= fin(ay_reg);
                    pt_index <= 6'(i_reg);
                    last     <= (CW'(i_reg) + CW'(1) == n_reg);
                    if (CW'(i_reg) + CW'(1) == n_reg)
                        state_reg <= S_IDLE;
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/cubic_bezier_point_generator_core.sv
// sequence: each point passes through S_LOAD, S_DIV (the bit-serial t divider), S_S, S_U, S_SQ,
//   S_W, S_AX and S_OUT before it is strobed; a single-point run skips S_DIV
// points are computed one at a time, the next starting only after the previous is strobed;
//   the sequencer returns through S_IDLE between transactions
// busy while the two entry command queue is full; receiver cannot stall results
// reset: asynchronous active low, clears queue and sequencer, no result pending
module cubic_bezier_point_generator_core #(
    parameter int MAX_POINTS  = cbpg_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS  = cbpg_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbpg_pkg::T_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] p0_x,
    input  logic signed [COORD_BITS-1:0] p0_y,
    input  logic signed [COORD_BITS-1:0] p1_x,
    input  logic signed [COORD_BITS-1:0] p1_y,
    input  logic signed [COORD_BITS-1:0] p2_x,
    input  logic signed [COORD_BITS-1:0] p2_y,
    input  logic signed [COORD_BITS-1:0] p3_x,
    input  logic signed [COORD_BITS-1:0] p3_y,
    input  logic [cbpg_pkg::CNT_W-1:0]   point_count,
    output logic                         strobe,
    output logic signed [COORD_BITS-1:0] pt_x,
    output logic signed [COORD_BITS-1:0] pt_y,
    output logic [5:0]                   pt_index,
    output logic                         last
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic signed [COORD_BITS-1:0] cx_in [4], cy_in [4], cx [4], cy [4];
    logic [CW-1:0] cnt;
    logic full, avail, pop, idle, push;

    assign cx_in = '{p0_x, p1_x, p2_x, p3_x};
    assign cy_in = '{p0_y, p1_y, p2_y, p3_y};
    // a transaction is taken whenever the queue has room
    assign busy = full;
    assign push = start && !busy;

    cbpg_front #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS), .CW(CW)) u_front (
        .clk, .rst_n, .push, .cx_in, .cy_in, .cnt_in(point_count),
        .full, .avail, .pop, .cx_out(cx), .cy_out(cy), .cnt_out(cnt)
    );

    cbpg_back #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS),
                .MAX_POINTS(MAX_POINTS), .CW(CW)) u_back (
        .clk, .rst_n, .avail, .pop, .idle, .cx, .cy, .cnt,
        .strobe, .pt_x, .pt_y, .pt_index, .last
    );

    // queue never pops when empty
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n) pop |-> avail)
        else $error("pop from empty queue");
    // pops happen only while the sequencer is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n) pop |-> idle)
        else $error("pop while sequencer busy");
    // results are single-cycle pulses
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n) strobe |=> !strobe)
        else $error("back to back strobe");
endmodule
